@@ src/gwm_pkg.sv @@
// Shared types, constants and a helper function for the glob wildcard matcher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gwm_pkg;

    // Pattern capacity and the widths that follow from it.
    localparam int PATTERN_MAX = 32;
    localparam int ACT_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = $clog2(PATTERN_MAX);

    // Depth of the queue between front and back, and of the result queue.
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Input command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_FEED   = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    // Slash mode codes; the unused code behaves as automatic.
    localparam logic [1:0] SLASH_AUTO   = 2'd0;
    localparam logic [1:0] SLASH_NEVER  = 2'd1;
    localparam logic [1:0] SLASH_ALWAYS = 2'd2;

    // Special pattern characters.
    localparam logic [15:0] CH_QUESTION  = 16'h003F;
    localparam logic [15:0] CH_STAR      = 16'h002A;
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_SLASH     = 16'h002F;
    localparam logic [15:0] CH_DOT       = 16'h002E;

    typedef enum logic [1:0] {
        KIND_LIT,
        KIND_ESC,
        KIND_ANY,
        KIND_STAR
    } kind_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_RESTART,
        OP_FEED,
        OP_FINISH
    } op_code_t;

    // One classified operation handed from the front to the back.
    typedef struct packed {
        op_code_t    code;
        kind_t       kind;
        logic [15:0] chr;
        logic        dot_slash;
        logic        lone_escape;
    } op_t;

    // One stored pattern element: kind, character and whether its raw
    // character is a slash or a dot.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] chr;
        logic        dot_slash;
    } element_t;

    typedef struct packed {
        logic matched;
        logic pattern_fault;
    } result_t;

    // Skip closure over a run of skippable positions. A carry that enters a
    // run of ones in the skip mask ripples to the first position past the run.
    function automatic logic [ACT_W-1:0] skip_closure(input logic [ACT_W-1:0] act,
                                                     input logic [ACT_W-1:0] skip);
        logic [ACT_W-1:0] sum;
        sum = (act & skip) + skip;
        return act | (sum ^ skip);
    endfunction

endpackage

@@ src/gwm_front.sv @@
// Front end: accepts input requests, tracks the pending escape and classifies
// each request into one operation for the back end. Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [1:0]       command,
    input  logic [15:0]      pattern_char,
    input  logic [7:0]       example_char,
    output gwm_pkg::op_t     op_out
);
    import gwm_pkg::*;

    logic escape_reg;
    logic escape_next;
    op_t  op;

    // Classify the request and work out the next escape state.
    always_comb
    begin
        op             = '0;
        op.code        = OP_RESTART;
        op.kind        = KIND_LIT;
        op.chr         = pattern_char;
        op.dot_slash   = 1'b0;
        op.lone_escape = escape_reg;
        escape_next    = escape_reg;
        case (command)
            CMD_CLEAR:
            begin
                op.code     = OP_CLEAR;
                escape_next = 1'b0;
            end
            CMD_APPEND:
            begin
                if (escape_reg)
                begin
                    op.code     = OP_APPEND;
                    op.kind     = KIND_ESC;
                    escape_next = 1'b0;
                end
                else if (pattern_char == CH_BACKSLASH)
                begin
                    op.code     = OP_RESTART;
                    escape_next = 1'b1;
                end
                else if (pattern_char == CH_QUESTION)
                begin
                    op.code = OP_APPEND;
                    op.kind = KIND_ANY;
                end
                else if (pattern_char == CH_STAR)
                begin
                    op.code = OP_APPEND;
                    op.kind = KIND_STAR;
                end
                else
                begin
                    op.code      = OP_APPEND;
                    op.kind      = KIND_LIT;
                    op.dot_slash = (pattern_char == CH_SLASH) || (pattern_char == CH_DOT);
                end
            end
            CMD_FEED:
            begin
                op.code = OP_FEED;
                op.chr  = {8'd0, example_char};
            end
            default:
            begin
                op.code = OP_FINISH;
            end
        endcase
    end

    assign op_out = op;

    // Escape state advances only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
        end
        else if (accept)
        begin
            escape_reg <= escape_next;
        end
    end

endmodule

@@ src/gwm_op_queue.sv @@
// Short queue of classified operations between the front and the back end.
// Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_op_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  gwm_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output gwm_pkg::op_t head_op,
    output logic         empty
);
    import gwm_pkg::*;

    op_t                  mem_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg;
    logic [OPQ_PTR_W-1:0] wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg;
    logic [OPQ_PTR_W-1:0] rd_ptr_next;
    logic [OPQ_CNT_W-1:0] count_reg;
    logic [OPQ_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ src/gwm_engine.sv @@
// Back end: holds the pattern, runs the bit-parallel position automaton and
// queues match results. Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_data,
    input  gwm_pkg::op_t op_in,
    input  logic         op_valid,
    output logic         op_take,
    input  logic         res_pop,
    output logic         res_empty,
    output logic         matched,
    output logic         pattern_fault
);
    import gwm_pkg::*;

    logic [1:0]           slash_mode_reg;
    element_t             elem_mem_reg [PATTERN_MAX];
    logic [LEN_W-1:0]     length_reg;
    logic [LEN_W-1:0]     length_next;
    logic                 fault_reg;
    logic                 fault_next;
    logic [ACT_W-1:0]     active_reg;
    logic [ACT_W-1:0]     active_next;

    result_t              res_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg;
    logic [RES_PTR_W-1:0] res_rd_reg;
    logic [RES_CNT_W-1:0] res_count_reg;
    logic [RES_CNT_W-1:0] res_count_next;
    logic                 res_full;
    logic                 res_push;
    logic                 res_do_pop;
    result_t              res_new;

    logic [ACT_W-1:0]     valid_v;
    logic [ACT_W-1:0]     star_m;
    logic [ACT_W-1:0]     any_m;
    logic [ACT_W-1:0]     dot_slash_v;
    logic [ACT_W-1:0]     closed_feed;
    logic [ACT_W-1:0]     closed_end;
    logic [ACT_W-1:0]     feed_next;
    logic                 is_slash;
    logic                 auto_mode;
    logic                 refuse;
    logic                 can_store;

    assign res_full   = (res_count_reg == RES_CNT_W'(RES_DEPTH));
    assign res_empty  = (res_count_reg == '0);
    assign op_take    = op_valid && ((op_in.code != OP_FINISH) || !res_full);
    assign res_push   = op_take && (op_in.code == OP_FINISH);
    assign res_do_pop = res_pop && !res_empty;
    assign can_store  = (length_reg < LEN_W'(PATTERN_MAX));

    // Per-position masks taken from the stored elements.
    always_comb
    begin
        valid_v     = '0;
        star_m      = '0;
        any_m       = '0;
        dot_slash_v = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            valid_v[i]     = (LEN_W'(i) < length_reg);
            star_m[i]      = valid_v[i] && (elem_mem_reg[i].kind == KIND_STAR);
            any_m[i]       = valid_v[i] && (elem_mem_reg[i].kind == KIND_ANY);
            dot_slash_v[i] = valid_v[i] && elem_mem_reg[i].dot_slash;
        end
    end

    // Star skipping before a byte, star and '?' skipping at the end.
    assign closed_feed = skip_closure(active_reg, star_m);
    assign closed_end  = skip_closure(active_reg, star_m | any_m);

    // One byte step over all positions at once.
    always_comb
    begin
        feed_next = '0;
        is_slash  = (op_in.chr == CH_SLASH);
        auto_mode = (slash_mode_reg != SLASH_NEVER) && (slash_mode_reg != SLASH_ALWAYS);
        refuse    = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            refuse = valid_v[i + 1] &&
                     ((slash_mode_reg == SLASH_NEVER) || (auto_mode && dot_slash_v[i + 1]));
            if (closed_feed[i] && valid_v[i])
            begin
                case (elem_mem_reg[i].kind)
                    KIND_ANY:
                    begin
                        feed_next[i + 1] = 1'b1;
                    end
                    KIND_STAR:
                    begin
                        if (!(is_slash && refuse))
                        begin
                            feed_next[i] = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (elem_mem_reg[i].chr == op_in.chr)
                        begin
                            feed_next[i + 1] = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Next pattern and automaton state for the operation at the head.
    always_comb
    begin
        length_next           = length_reg;
        fault_next            = fault_reg;
        active_next           = active_reg;
        res_new.pattern_fault = fault_reg || op_in.lone_escape;
        res_new.matched       = closed_end[length_reg] && !res_new.pattern_fault;
        if (op_take)
        begin
            case (op_in.code)
                OP_CLEAR:
                begin
                    length_next = '0;
                    fault_next  = 1'b0;
                    active_next = ACT_W'(1);
                end
                OP_APPEND:
                begin
                    if (can_store)
                    begin
                        length_next = length_reg + 1'b1;
                    end
                    else
                    begin
                        fault_next = 1'b1;
                    end
                    active_next = ACT_W'(1);
                end
                OP_FEED:
                begin
                    active_next = feed_next;
                end
                default:
                begin
                    active_next = ACT_W'(1);
                end
            endcase
        end
    end

    // Result queue fill count.
    always_comb
    begin
        res_count_next = res_count_reg;
        if (res_push && !res_do_pop)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (res_do_pop && !res_push)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slash_mode_reg <= SLASH_AUTO;
            length_reg     <= '0;
            fault_reg      <= 1'b0;
            active_reg     <= ACT_W'(1);
            res_wr_reg     <= '0;
            res_rd_reg     <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                slash_mode_reg <= cfg_data;
            end
            length_reg    <= length_next;
            fault_reg     <= fault_next;
            active_reg    <= active_next;
            res_count_reg <= res_count_next;
            if (res_push)
            begin
                res_wr_reg <= (res_wr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : res_wr_reg + 1'b1;
            end
            if (res_do_pop)
            begin
                res_rd_reg <= (res_rd_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : res_rd_reg + 1'b1;
            end
        end
    end

    // Pattern and result storage need no reset.
    always_ff @(posedge clk)
    begin
        if (op_take && (op_in.code == OP_APPEND) && can_store)
        begin
            elem_mem_reg[length_reg[IDX_W-1:0]] <= '{kind: op_in.kind, chr: op_in.chr,
                                                     dot_slash: op_in.dot_slash};
        end
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_new;
        end
    end

    assign matched       = res_mem_reg[res_rd_reg].matched;
    assign pattern_fault = res_mem_reg[res_rd_reg].pattern_fault;

endmodule

@@ src/glob_wildcard_matcher_unit.sv @@
// Top level of the glob wildcard matcher: front classifier, operation queue
// and matching engine. Depends on gwm_pkg, gwm_front, gwm_op_queue, gwm_engine.
`timescale 1ns / 1ps

// The block takes one request per clock cycle while full is low, for every
// command: pattern clears and appends, example bytes and end-of-example
// markers. Each request is classified on entry and lands in a four-entry
// queue; the engine executes one queued operation per cycle unless an
// end-of-example operation waits on a full result queue, updating all
// pattern positions at once, so an example byte costs the same however
// long the pattern is. An end-of-example request reaches the result ports
// through the operation queue and a two-entry result queue; full rises only
// when the result side has stalled long enough to back up both queues.
// There is no clearing pass after reset. The configuration channel is always
// ready and should be written only while no request is in flight.
module glob_wildcard_matcher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [15:0] pattern_char,
    input  logic [7:0]  example_char,
    output logic        empty,
    input  logic        pop,
    output logic        matched,
    output logic        pattern_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import gwm_pkg::*;

    op_t  front_op;
    op_t  head_op;
    logic accept;
    logic queue_empty;
    logic op_take;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    // Classify incoming requests.
    gwm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .pattern_char (pattern_char),
        .example_char (example_char),
        .op_out       (front_op)
    );

    // Decouple the front from the engine.
    gwm_op_queue u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .full    (full),
        .pop     (op_take),
        .head_op (head_op),
        .empty   (queue_empty)
    );

    // Execute operations and queue results.
    gwm_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .op_in         (head_op),
        .op_valid      (!queue_empty),
        .op_take       (op_take),
        .res_pop       (pop),
        .res_empty     (empty),
        .matched       (matched),
        .pattern_fault (pattern_fault)
    );

endmodule

@@ tb/glob_wildcard_matcher_unit_tb.sv @@
// Self-checking testbench for glob_wildcard_matcher_unit: a scoreboard class predicts every
// end-of-example result from the accepted requests and checks each popped result.
// Depends on gwm_pkg and the glob_wildcard_matcher_unit RTL.
`timescale 1ns / 1ps

module glob_wildcard_matcher_unit_tb;

    import gwm_pkg::*;

    // Slash mode code that the block treats as automatic.
    localparam logic [1:0] SLASH_RESERVED = 2'd3;
    // Plain letters used to build patterns and examples.
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 360;
    localparam int PRESSURE_AT   = 30;
    localparam int PRESSURE_LEN  = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  command;
    logic [15:0] pattern_char;
    logic [7:0]  example_char;
    logic        empty;
    logic        pop;
    logic        matched;
    logic        pattern_fault;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    int          items_sent = 0;
    logic [15:0] pattern_toks[$];
    logic [7:0]  example_bytes[$];

    // Predicts the match automaton and keeps the results still to come.
    class match_scoreboard;
        kind_t            elem_kind[PATTERN_MAX];
        logic [15:0]      elem_chr[PATTERN_MAX];
        int               pat_len;
        bit               esc_pending;
        bit               overflowed;
        logic [ACT_W-1:0] live;
        logic [1:0]       slash_mode;
        result_t          expected_q[$];
        int               errors;

        function new();
            pat_len     = 0;
            esc_pending = 1'b0;
            overflowed  = 1'b0;
            slash_mode  = SLASH_AUTO;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            live    = '0;
            live[0] = 1'b1;
        endfunction

        function void set_slash_mode(logic [1:0] mode);
            slash_mode = mode;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // The pattern character as it was written, before classification.
        function logic [15:0] raw_char(int i);
            case (elem_kind[i])
                KIND_ESC:  return CH_BACKSLASH;
                KIND_ANY:  return CH_QUESTION;
                KIND_STAR: return CH_STAR;
                default:   return elem_chr[i];
            endcase
        endfunction

        // A trailing star never refuses a slash.
        function bit refuses_slash(int i);
            logic [15:0] r;
            if (i + 1 >= pat_len) return 1'b0;
            if (slash_mode == SLASH_NEVER) return 1'b1;
            if (slash_mode == SLASH_ALWAYS) return 1'b0;
            r = raw_char(i + 1);
            return (r == CH_SLASH) || (r == CH_DOT);
        endfunction

        // Stars can be skipped; at the end of the example so can '?'.
        function void skip_ahead(bit at_end);
            for (int i = 0; i < pat_len; i++) begin
                if (live[i] && (elem_kind[i] == KIND_STAR ||
                                (at_end && elem_kind[i] == KIND_ANY)))
                    live[i + 1] = 1'b1;
            end
        endfunction

        function void add_element(kind_t k, logic [15:0] ch);
            if (pat_len >= PATTERN_MAX) begin
                overflowed = 1'b1;
                return;
            end
            elem_kind[pat_len] = k;
            elem_chr[pat_len]  = ch;
            pat_len++;
        endfunction

        function void feed(logic [7:0] c);
            logic [ACT_W-1:0] nxt;
            nxt = '0;
            skip_ahead(1'b0);
            for (int i = 0; i < pat_len; i++) begin
                if (live[i]) begin
                    case (elem_kind[i])
                        KIND_ANY:  nxt[i + 1] = 1'b1;
                        KIND_STAR: if (!({8'h00, c} == CH_SLASH && refuses_slash(i)))
                            nxt[i] = 1'b1;
                        default:   if (elem_chr[i] == {8'h00, c}) nxt[i + 1] = 1'b1;
                    endcase
                end
            end
            live = nxt;
        endfunction

        // Advances the model by one accepted request.
        function void note_request(logic [1:0] cmd, logic [15:0] pch, logic [7:0] ech);
            result_t res;
            bit      flt;
            case (cmd)
                CMD_CLEAR: begin
                    pat_len     = 0;
                    esc_pending = 1'b0;
                    overflowed  = 1'b0;
                    restart();
                end
                CMD_APPEND: begin
                    if (esc_pending) begin
                        esc_pending = 1'b0;
                        add_element(KIND_ESC, pch);
                    end else if (pch == CH_BACKSLASH) begin
                        esc_pending = 1'b1;
                    end else if (pch == CH_QUESTION) begin
                        add_element(KIND_ANY, pch);
                    end else if (pch == CH_STAR) begin
                        add_element(KIND_STAR, pch);
                    end else begin
                        add_element(KIND_LIT, pch);
                    end
                    restart();
                end
                CMD_FEED: feed(ech);
                default: begin
                    skip_ahead(1'b1);
                    flt               = overflowed || esc_pending;
                    res.matched       = live[pat_len] && !flt;
                    res.pattern_fault = flt;
                    expected_q.push_back(res);
                    restart();
                end
            endcase
        endfunction

        // Compares one popped result with the oldest prediction.
        function void check_result(logic m, logic f);
            result_t exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no request waiting: matched %0d pattern_fault %0d", m, f);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (m !== exp_res.matched) begin
                $error("matched: expected %0d, actual %0d", exp_res.matched, m);
                errors++;
            end
            if (f !== exp_res.pattern_fault) begin
                $error("pattern_fault: expected %0d, actual %0d", exp_res.pattern_fault, f);
                errors++;
            end
        endfunction
    endclass

    match_scoreboard board = new();

    glob_wildcard_matcher_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .pattern_char (pattern_char),
        .example_char (example_char),
        .empty        (empty),
        .pop          (pop),
        .matched      (matched),
        .pattern_fault(pattern_fault),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 16'($urandom_range(0, 65535));
        if (r < 18) return 16'($urandom_range(0, 255));
        case ($urandom_range(0, 6))
            0:       return {8'h00, CH_A};
            1:       return {8'h00, CH_B};
            2:       return CH_SLASH;
            3:       return CH_DOT;
            4:       return CH_QUESTION;
            5:       return CH_STAR;
            default: return CH_BACKSLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_example_byte();
        if ($urandom_range(0, 99) < 30) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_SLASH[7:0];
            default: return CH_DOT[7:0];
        endcase
    endfunction

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] pch,
                             input logic [7:0] ech);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        command      <= cmd;
        pattern_char <= pch;
        example_char <= ech;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_request(cmd, pch, ech);
        items_sent++;
    endtask

    task automatic send_append(input logic [15:0] ch);
        send_item(CMD_APPEND, ch, 8'($urandom));
    endtask

    task automatic send_feed(input logic [7:0] b);
        send_item(CMD_FEED, 16'($urandom), b);
    endtask

    task automatic send_finish();
        send_item(CMD_FINISH, 16'($urandom), 8'($urandom));
    endtask

    task automatic send_clear();
        send_item(CMD_CLEAR, 16'($urandom), 8'($urandom));
    endtask

    // Waits until every result is in and the operation queue has drained.
    task automatic settle();
        push <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slash_mode(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_slash_mode(mode);
    endtask

    // Hand-picked requests: wide and zero characters, automatic slash
    // refusal, escapes, append during an example, trailing '?' and a lone
    // backslash.
    task automatic run_directed();
        send_clear();
        send_append(16'hFFFF);
        send_finish();
        send_clear();
        send_append(CH_STAR);
        send_append(CH_DOT);
        send_feed(CH_SLASH[7:0]);
        send_feed(CH_DOT[7:0]);
        send_finish();
        send_feed(8'hFF);
        send_feed(CH_DOT[7:0]);
        send_finish();
        send_append(CH_BACKSLASH);
        send_append(CH_STAR);
        send_feed(8'h00);
        send_feed(CH_DOT[7:0]);
        send_feed(CH_STAR[7:0]);
        send_finish();
        send_feed(8'h7A);
        send_append(CH_QUESTION);
        send_feed(CH_DOT[7:0]);
        send_feed(CH_STAR[7:0]);
        send_finish();
        send_append(CH_BACKSLASH);
        send_finish();
        send_append(16'h0000);
    endtask

    // Derives an example from the current pattern so that many examples
    // match, then damages some of them.
    task automatic build_example();
        int          i;
        logic [15:0] t;
        example_bytes.delete();
        i = 0;
        while (i < pattern_toks.size()) begin
            t = pattern_toks[i];
            if (t == CH_BACKSLASH && i + 1 < pattern_toks.size()) begin
                t = pattern_toks[i + 1];
                example_bytes.push_back(t < 16'd256 ? t[7:0] : pick_example_byte());
                i += 2;
            end else begin
                if (t == CH_STAR)
                    repeat ($urandom_range(0, 3)) example_bytes.push_back(pick_example_byte());
                else if (t == CH_QUESTION) begin
                    if ($urandom_range(0, 99) < 85) example_bytes.push_back(pick_example_byte());
                end else if (t != CH_BACKSLASH)
                    example_bytes.push_back(t < 16'd256 ? t[7:0] : pick_example_byte());
                i++;
            end
        end
        if ($urandom_range(0, 99) < 25 && example_bytes.size() > 0)
            example_bytes[$urandom_range(0, example_bytes.size() - 1)] = pick_example_byte();
        if ($urandom_range(0, 99) < 10) example_bytes.push_back(pick_example_byte());
    endtask

    // Mostly well-formed pattern and example sequences, some raw noise.
    task automatic run_random_phase(input int count);
        int          target;
        int          n;
        logic [15:0] t;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 9) begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom), 16'($urandom), 8'($urandom));
            end else begin
                send_clear();
                n = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 36)
                                                : $urandom_range(1, 8);
                pattern_toks.delete();
                repeat (n) begin
                    t = pick_pattern_char();
                    pattern_toks.push_back(t);
                    send_append(t);
                end
                repeat ($urandom_range(1, 4)) begin
                    build_example();
                    foreach (example_bytes[k]) begin
                        if ($urandom_range(0, 99) < 2) begin
                            t = pick_pattern_char();
                            pattern_toks.push_back(t);
                            send_append(t);
                        end
                        send_feed(example_bytes[k]);
                    end
                    send_finish();
                end
            end
        end
    endtask

    // Result side: random stalls, plus one long hold that backs up the block.
    initial begin : result_sink
        int stall_left;
        int results_seen;
        bit hold_done;
        stall_left   = 0;
        results_seen = 0;
        hold_done    = 1'b0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                board.check_result(matched, pattern_fault);
                results_seen++;
            end
            if (!hold_done && results_seen >= PRESSURE_AT) begin
                hold_done  = 1'b1;
                stall_left = PRESSURE_LEN;
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Run limit.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, directed requests, then random phases under each slash mode.
    initial begin : stimulus
        push         <= 1'b0;
        command      <= CMD_CLEAR;
        pattern_char <= '0;
        example_char <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= SLASH_AUTO;
        rst_n        <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_slash_mode(SLASH_AUTO);
        run_directed();
        settle();
        write_slash_mode(SLASH_NEVER);
        run_random_phase(PHASE_ITEMS);
        settle();
        write_slash_mode(SLASH_ALWAYS);
        run_random_phase(PHASE_ITEMS);
        settle();
        write_slash_mode(SLASH_RESERVED);
        run_random_phase(PHASE_ITEMS);
        settle();
        write_slash_mode(SLASH_AUTO);
        run_random_phase(PHASE_ITEMS);
        settle();
        write_slash_mode(2'($urandom_range(0, 3)));
        run_random_phase(PHASE_ITEMS);
        settle();
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
